// ----- design/ppt_pkg.sv -----
package ppt_pkg;

  localparam int FUNC_W      = 3;
  localparam int SLOT_W      = 6;
  localparam int PAYLOAD_W   = 32;
  localparam int STATUS_W    = 2;
  localparam int PRIORITY_W  = 16;
  // Wide enough for any supported table size (up to 4096 entries) plus one.
  localparam int ID_EXT_W    = 13;
  localparam int PAY_EXT_W   = 64;
  localparam int PRI_EXT_W   = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD      = 3'd0,
    FN_IS_VALID = 3'd1,
    FN_GET      = 3'd2,
    FN_PROMOTE  = 3'd3,
    FN_GET_MAX  = 3'd4,
    FN_POP_MAX  = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BADID = 2'd3
  } status_t;

endpackage

// ----- design/promotable_priority_table_top.sv -----
// Priority table with promote. Every entry (live flag, priority, payload word) sits in one
// single-port-read, single-port-write memory. An item is taken when start is high and busy is
// low; its one result appears for exactly one cycle with out_valid high and cannot be held off.
// Add, is_valid, get and promote pass through the look state (a memory read for all but add,
// then the update or write back) before the result, so busy falls in the result cycle and the
// next item can be taken there. get_max and pop_max walk the table through the memory read
// port, one entry per cycle, over every id handed out so far, then give their result. Ids at
// or above the count of ids handed out since reset have never been written, so the live
// flags are qualified by that count and the memory needs no clearing pass after reset.
module promotable_priority_table_top #(
  parameter int ENTRIES       = 64,
  parameter int PRIORITY_BITS = 16,
  parameter int PAYLOAD_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [ppt_pkg::FUNC_W-1:0]     in_func,
  input  logic [ppt_pkg::SLOT_W-1:0]     in_slot_id,
  input  logic [ppt_pkg::PAYLOAD_W-1:0]  in_payload_in,
  output logic                           out_valid,
  output logic [ppt_pkg::STATUS_W-1:0]   out_status,
  output logic [ppt_pkg::SLOT_W-1:0]     out_id_out,
  output logic [ppt_pkg::PAYLOAD_W-1:0]  out_payload_out,
  output logic [ppt_pkg::PRIORITY_W-1:0] out_priority_out,
  output logic                           out_is_valid
);

  localparam int IDW  = $clog2(ENTRIES);
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam int EW   = 1 + PRIORITY_BITS + PAYLOAD_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN
  } state_t;

  state_t                          state_r;
  ppt_pkg::func_t                  func_r;
  logic [ppt_pkg::ID_EXT_W-1:0]    slot_r;
  logic [PAYLOAD_BITS-1:0]         pay_r;
  logic [CNTW-1:0]                 next_id_r;
  logic [CNTW-1:0]                 scan_addr_r;
  logic                            data_vld_r;
  logic [IDW-1:0]                  data_idx_r;
  logic                            found_r;
  logic [IDW-1:0]                  best_idx_r;
  logic [PRIORITY_BITS-1:0]        best_pri_r;
  logic [PAYLOAD_BITS-1:0]         best_pay_r;

  logic                            out_valid_r;
  ppt_pkg::status_t                status_r;
  logic [ppt_pkg::SLOT_W-1:0]      id_out_r;
  logic [ppt_pkg::PAYLOAD_W-1:0]   pay_out_r;
  logic [ppt_pkg::PRIORITY_W-1:0]  pri_out_r;
  logic                            is_valid_r;

  logic                            rd_en;
  logic [IDW-1:0]                  rd_addr;
  logic [EW-1:0]                   rd_data;
  logic                            wr_en;
  logic [IDW-1:0]                  wr_addr;
  logic [EW-1:0]                   wr_data;

  logic [ppt_pkg::ID_EXT_W-1:0]    slot_ext;
  logic [ppt_pkg::PAY_EXT_W-1:0]   pay_in_ext;
  logic                            rd_live;
  logic [PRIORITY_BITS-1:0]        rd_pri;
  logic [PAYLOAD_BITS-1:0]         rd_pay;
  logic [PRIORITY_BITS-1:0]        pri_inc;
  logic                            id_live;
  logic                            add_ok;
  logic                            scan_issue;
  logic                            scan_done;
  logic                            take;
  logic                            accept;
  logic                            in_is_scan;
  logic                            in_needs_read;
  logic [ppt_pkg::ID_EXT_W-1:0]    add_id_ext;
  logic [ppt_pkg::ID_EXT_W-1:0]    best_id_ext;
  logic [ppt_pkg::PAY_EXT_W-1:0]   rd_pay_ext;
  logic [ppt_pkg::PAY_EXT_W-1:0]   best_pay_ext;
  logic [ppt_pkg::PRI_EXT_W-1:0]   best_pri_ext;

  assign slot_ext     = ppt_pkg::ID_EXT_W'(in_slot_id);
  assign pay_in_ext   = ppt_pkg::PAY_EXT_W'(in_payload_in);
  assign rd_live      = rd_data[EW-1];
  assign rd_pri       = rd_data[EW-2 -: PRIORITY_BITS];
  assign rd_pay       = rd_data[PAYLOAD_BITS-1:0];
  assign pri_inc      = (rd_pri == {PRIORITY_BITS{1'b1}}) ? rd_pri
                                                          : rd_pri + PRIORITY_BITS'(1);
  // An id is live only if it was handed out and has not been popped since.
  assign id_live      = (slot_r < ppt_pkg::ID_EXT_W'(next_id_r)) && rd_live;
  assign add_ok       = next_id_r < CNTW'(ENTRIES);
  assign scan_issue   = scan_addr_r < next_id_r;
  assign scan_done    = !scan_issue && !data_vld_r;
  // Entries arrive in rising id order, so >= lets the newest id win a tie.
  assign take         = data_vld_r && rd_live && (!found_r || rd_pri >= best_pri_r);
  assign accept       = start && !busy;
  assign in_is_scan   = (in_func == ppt_pkg::FN_GET_MAX) || (in_func == ppt_pkg::FN_POP_MAX);
  assign in_needs_read = (in_func == ppt_pkg::FN_IS_VALID) || (in_func == ppt_pkg::FN_GET) ||
                         (in_func == ppt_pkg::FN_PROMOTE);
  assign add_id_ext   = ppt_pkg::ID_EXT_W'(next_id_r);
  assign best_id_ext  = ppt_pkg::ID_EXT_W'(best_idx_r);
  assign rd_pay_ext   = ppt_pkg::PAY_EXT_W'(rd_pay);
  assign best_pay_ext = ppt_pkg::PAY_EXT_W'(best_pay_r);
  assign best_pri_ext = ppt_pkg::PRI_EXT_W'(best_pri_r);

  ppt_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = slot_ext[IDW-1:0];
    wr_en   = 1'b0;
    wr_addr = next_id_r[IDW-1:0];
    wr_data = {1'b1, {PRIORITY_BITS{1'b0}}, pay_r};
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_needs_read) begin
          rd_en = 1'b1;
        end
      end
      S_LOOK: begin
        if (func_r == ppt_pkg::FN_ADD && add_ok) begin
          wr_en = 1'b1;
        end else if (func_r == ppt_pkg::FN_PROMOTE && id_live) begin
          wr_en   = 1'b1;
          wr_addr = slot_r[IDW-1:0];
          wr_data = {1'b1, pri_inc, rd_pay};
        end
      end
      S_SCAN: begin
        if (scan_issue) begin
          rd_en   = 1'b1;
          rd_addr = scan_addr_r[IDW-1:0];
        end
        if (scan_done && found_r && func_r == ppt_pkg::FN_POP_MAX) begin
          wr_en   = 1'b1;
          wr_addr = best_idx_r;
          wr_data = {1'b0, best_pri_r, best_pay_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      next_id_r   <= '0;
      data_vld_r  <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r      <= ppt_pkg::func_t'(in_func);
            slot_r      <= slot_ext;
            pay_r       <= pay_in_ext[PAYLOAD_BITS-1:0];
            scan_addr_r <= '0;
            data_vld_r  <= 1'b0;
            found_r     <= 1'b0;
            state_r     <= in_is_scan ? S_SCAN : S_LOOK;
          end
        end
        S_LOOK: begin
          out_valid_r <= 1'b1;
          status_r    <= ppt_pkg::ST_OK;
          id_out_r    <= '0;
          pay_out_r   <= '0;
          pri_out_r   <= '0;
          is_valid_r  <= 1'b0;
          state_r     <= S_IDLE;
          unique case (func_r)
            ppt_pkg::FN_ADD: begin
              if (add_ok) begin
                id_out_r  <= add_id_ext[ppt_pkg::SLOT_W-1:0];
                next_id_r <= next_id_r + CNTW'(1);
              end else begin
                status_r <= ppt_pkg::ST_FULL;
              end
            end
            ppt_pkg::FN_IS_VALID: begin
              is_valid_r <= id_live;
            end
            ppt_pkg::FN_GET: begin
              if (id_live) begin
                pay_out_r <= rd_pay_ext[ppt_pkg::PAYLOAD_W-1:0];
              end else begin
                status_r <= ppt_pkg::ST_BADID;
              end
            end
            ppt_pkg::FN_PROMOTE: begin
              if (!id_live) begin
                status_r <= ppt_pkg::ST_BADID;
              end
            end
            default: begin
            end
          endcase
        end
        S_SCAN: begin
          if (take) begin
            found_r    <= 1'b1;
            best_idx_r <= data_idx_r;
            best_pri_r <= rd_pri;
            best_pay_r <= rd_pay;
          end
          data_vld_r <= scan_issue;
          if (scan_issue) begin
            data_idx_r  <= scan_addr_r[IDW-1:0];
            scan_addr_r <= scan_addr_r + CNTW'(1);
          end
          if (scan_done) begin
            out_valid_r <= 1'b1;
            is_valid_r  <= 1'b0;
            state_r     <= S_IDLE;
            if (found_r) begin
              status_r  <= ppt_pkg::ST_OK;
              id_out_r  <= best_id_ext[ppt_pkg::SLOT_W-1:0];
              pay_out_r <= best_pay_ext[ppt_pkg::PAYLOAD_W-1:0];
              pri_out_r <= best_pri_ext[ppt_pkg::PRIORITY_W-1:0];
            end else begin
              status_r  <= ppt_pkg::ST_EMPTY;
              id_out_r  <= '0;
              pay_out_r <= '0;
              pri_out_r <= '0;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_id_out       = id_out_r;
  assign out_payload_out  = pay_out_r;
  assign out_priority_out = pri_out_r;
  assign out_is_valid     = is_valid_r;

  // Exactly one result per transfer: never two result cycles in a row.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not make the block busy");

  a_id_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r <= CNTW'(ENTRIES))
    else $error("id counter ran past the table size");

  a_full_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ppt_pkg::ST_FULL) |-> (next_id_r == CNTW'(ENTRIES)))
    else $error("table full reported before all ids were used");

endmodule

// ----- design/ppt_mem.sv -----
module ppt_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 49
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
